FILE: src/swtb_pkg.sv
// Shared types and constants for the software timer bank.
// Holds command codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package swtb_pkg;

    // Command codes carried in the action field
    localparam logic [2:0] ACT_TICK       = 3'd0;
    localparam logic [2:0] ACT_CREATE     = 3'd1;
    localparam logic [2:0] ACT_DELETE     = 3'd2;
    localparam logic [2:0] ACT_PAUSE      = 3'd3;
    localparam logic [2:0] ACT_RESUME     = 3'd4;
    localparam logic [2:0] ACT_RELOAD     = 3'd5;
    localparam logic [2:0] ACT_SET_AUTO   = 3'd6;
    localparam logic [2:0] ACT_SET_RELOAD = 3'd7;

    // Width of the result fields that do not follow a parameter
    localparam int MASK_W = 8;
    localparam int TICK_W = 32;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // request taken this cycle
        logic is_tick;   // taken request is a tick
        logic step;      // process one timer entry of the walk
        logic load_out;  // move the finished result to the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last_entry;  // walk index sits on the last timer
        logic out_free;    // output register can take a result this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: src/swtb_ctrl.sv
// Controller for the software timer bank: idle, walk and result-hand-off states.
// Depends on swtb_pkg for the command codes and interface structs.
`default_nettype none

module swtb_ctrl import swtb_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [2:0] i_in_action,
    input  wire t_dp_sts    i_sts,
    output logic            o_in_stall,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and command decode
    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.is_tick  = (i_in_action == ACT_TICK);
        o_cmd.step     = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_in_action == ACT_TICK) ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_entry) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // One request at a time
    assign o_in_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

FILE: src/swtb_dp.sv
// Datapath for the software timer bank: timer entry store, walk index,
// run-time counter and output register. Depends on swtb_pkg.
`default_nettype none

module swtb_dp import swtb_pkg::*; #(
    parameter int NUM_TIMERS  = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [2:0]        i_in_action,
    input  wire logic [3:0]        i_in_timer_id,
    input  wire logic [31:0]       i_in_reload_value,
    input  wire logic              i_in_auto_reload,
    input  wire logic              i_in_start_now,
    input  wire logic              i_out_stall,
    output t_dp_sts                o_sts,
    output logic                   o_out_valid,
    output logic [MASK_W-1:0]      o_out_fired_mask,
    output logic [TICK_W-1:0]      o_out_run_time,
    output logic                   o_out_bad_id
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // Timer entry store
    logic [COUNT_WIDTH-1:0] r_reload [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] r_count  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  r_enable;
    logic [NUM_TIMERS-1:0]  r_auto;

    logic [IDX_W-1:0]  r_idx;
    logic [TICK_W-1:0] r_ticks;
    logic [MASK_W-1:0] r_mask;
    logic              r_bad;
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_mask;
    logic [TICK_W-1:0] r_out_time;
    logic              r_out_bad;

    logic                   id_bad;
    logic                   op_write;
    logic [IDX_W-1:0]       addr;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] cur_reload;
    logic                   cur_en;
    logic                   cur_auto;
    logic [COUNT_WIDTH-1:0] dec_count;
    logic                   fire;
    logic                   we;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] n_reload;
    logic                   n_en;
    logic                   n_auto;
    logic [COUNT_WIDTH-1:0] value;

    assign id_bad   = ({1'b0, i_in_timer_id} >= 5'(NUM_TIMERS));
    assign op_write = i_cmd.accept && !i_cmd.is_tick && !id_bad;
    assign addr     = i_cmd.step ? r_idx : i_in_timer_id[IDX_W-1:0];
    assign value    = i_in_reload_value[COUNT_WIDTH-1:0];

    // Read the addressed entry
    assign cur_count  = r_count[addr];
    assign cur_reload = r_reload[addr];
    assign cur_en     = r_enable[addr];
    assign cur_auto   = r_auto[addr];

    // Tick step: decrement, then fire on zero
    assign dec_count = (cur_count != '0) ? (cur_count - 1'b1) : cur_count;
    assign fire      = i_cmd.step && cur_en && (dec_count == '0);

    // Next entry contents for a walk step or a command
    always_comb begin
        n_count  = cur_count;
        n_reload = cur_reload;
        n_en     = cur_en;
        n_auto   = cur_auto;
        we       = 1'b0;
        if (i_cmd.step) begin
            we = 1'b1;
            if (cur_en) begin
                n_count = dec_count;
                if (dec_count == '0) begin
                    if (cur_auto) begin
                        n_count = cur_reload;
                    end else begin
                        n_count  = '0;
                        n_reload = '0;
                        n_en     = 1'b0;
                        n_auto   = 1'b0;
                    end
                end
            end
        end else if (op_write) begin
            we = 1'b1;
            case (i_in_action)
                ACT_CREATE: begin
                    n_reload = value;
                    n_count  = value;
                    n_auto   = i_in_auto_reload;
                    n_en     = i_in_start_now;
                end
                ACT_DELETE: begin
                    n_count  = '0;
                    n_reload = '0;
                    n_en     = 1'b0;
                    n_auto   = 1'b0;
                end
                ACT_PAUSE:      n_en     = 1'b0;
                ACT_RESUME:     n_en     = 1'b1;
                ACT_RELOAD:     n_count  = cur_reload;
                ACT_SET_AUTO:   n_auto   = i_in_auto_reload;
                ACT_SET_RELOAD: n_reload = value;
                default:        we       = 1'b0;
            endcase
        end
    end

    // Entry store, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_reload[i] <= '0;
                r_count[i]  <= '0;
            end
            r_enable <= '0;
            r_auto   <= '0;
        end else if (we) begin
            r_reload[addr] <= n_reload;
            r_count[addr]  <= n_count;
            r_enable[addr] <= n_en;
            r_auto[addr]   <= n_auto;
        end
    end

    // Walk index, run-time counter and pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_ticks <= '0;
            r_mask  <= '0;
            r_bad   <= 1'b0;
        end else if (i_cmd.accept) begin
            r_idx  <= '0;
            r_mask <= '0;
            if (i_cmd.is_tick) begin
                r_ticks <= r_ticks + 1'b1;
                r_bad   <= 1'b0;
            end else begin
                r_bad <= id_bad;
            end
        end else if (i_cmd.step) begin
            r_idx  <= r_idx + 1'b1;
            r_mask <= r_mask | (MASK_W'(fire) << r_idx);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_mask <= r_mask;
            r_out_time <= r_ticks;
            r_out_bad  <= r_bad;
        end
    end

    assign o_sts.last_entry = (r_idx == IDX_W'(NUM_TIMERS - 1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_out_fired_mask = r_out_mask;
    assign o_out_run_time   = r_out_time;
    assign o_out_bad_id     = r_out_bad;

endmodule

`default_nettype wire

FILE: src/software_timer_bank_core.sv
// Software timer bank: NUM_TIMERS down-counting timers driven by a request
// stream. One request is taken at a time and gives exactly one result. A
// command request (create, delete, pause, resume, reload, set auto-reload,
// set reload value) goes straight from acceptance to the done state, which
// loads its result into the output register. A tick first walks the timer
// store one entry per cycle and then enters the done state in the same way.
// The next request is taken while the previous result still waits in the
// output register; a finished request then holds in the done state, with
// the input stalled, until the output register frees up. The store is
// cleared by reset directly; no clearing pass is needed.
`default_nettype none

module software_timer_bank_core import swtb_pkg::*; #(
    parameter int NUM_TIMERS  = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [2:0]        i_in_action,
    input  wire logic [3:0]        i_in_timer_id,
    input  wire logic [31:0]       i_in_reload_value,
    input  wire logic              i_in_auto_reload,
    input  wire logic              i_in_start_now,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [MASK_W-1:0]      o_out_fired_mask,
    output logic [TICK_W-1:0]      o_out_run_time,
    output logic                   o_out_bad_id
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    swtb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_action),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    swtb_dp #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_in_action       (i_in_action),
        .i_in_timer_id     (i_in_timer_id),
        .i_in_reload_value (i_in_reload_value),
        .i_in_auto_reload  (i_in_auto_reload),
        .i_in_start_now    (i_in_start_now),
        .i_out_stall       (i_out_stall),
        .o_sts             (sts),
        .o_out_valid       (o_out_valid),
        .o_out_fired_mask  (o_out_fired_mask),
        .o_out_run_time    (o_out_run_time),
        .o_out_bad_id      (o_out_bad_id)
    );

endmodule

`default_nettype wire

FILE: src/swtb_checker.sv
// Port-level checks for the software timer bank, bound to the top level.
// Depends on swtb_pkg for result field widths.
`default_nettype none

module swtb_checker import swtb_pkg::*; #(
    parameter int NUM_TIMERS = 8
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [MASK_W-1:0] o_out_fired_mask,
    input wire logic [TICK_W-1:0] o_out_run_time,
    input wire logic              o_out_bad_id
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_fired_mask)
            && $stable(o_out_run_time) && $stable(o_out_bad_id))
        else $error("stalled result changed");

    // Only one request in flight: stall rises right after acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");

    // Rejected ids never report fired timers
    a_bad_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_bad_id |-> o_out_fired_mask == '0)
        else $error("bad id result with fired timers");

    // No mask bits beyond the existing timers
    a_mask_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (NUM_TIMERS >= MASK_W) || ((o_out_fired_mask >> NUM_TIMERS) == '0))
        else $error("fired bit for a missing timer");

endmodule

bind software_timer_bank_core swtb_checker #(.NUM_TIMERS(NUM_TIMERS)) u_swtb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_out_fired_mask (o_out_fired_mask),
    .o_out_run_time   (o_out_run_time),
    .o_out_bad_id     (o_out_bad_id)
);

`default_nettype wire
